@@ rtl/rgb_to_hsl_hwb_converter_macros.svh @@
// Assertion macros for the RGB to HSL/HWB converter.
// No dependencies; included by modules that carry assertions.
`ifndef RGB_TO_HSL_HWB_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_HWB_CONVERTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RHH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhh assertion failed");
`define RHH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhh assertion failed");
`else
`define RHH_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RHH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rhh_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the RGB to HSL/HWB converter.
// No dependencies.
package rhh_pkg;
    localparam int FRACTION_BITS_DEF = 12;
    localparam int HUE_FULL          = 23040;
    localparam int HUE_HALF          = 11520;
    localparam int HUE_GREEN         = 7680;
    localparam int HUE_BLUE          = 15360;
    localparam int HUE_NUM_SCALE     = 7680;
    localparam int SAT_NUM_SCALE     = 12800;
    localparam int QUO_W             = 17;
    localparam int HNUM_W            = 28;
    localparam int HDEN_W            = 15;
    localparam int SNUM_W            = 30;
    localparam int PROD_W            = 40;
    localparam logic [QUO_W-1:0] SAT_MAX = '1;

    typedef struct packed {
        logic signed [13:0] mx;
        logic signed [13:0] mn;
        logic [14:0]        d;
        logic signed [14:0] sum;
        logic signed [14:0] diff;
        logic [14:0]        base;
        logic               defined;
        logic               mode;
        logic [12:0]        alpha;
    } t_item;

    typedef struct packed {
        logic                      hue_neg;
        logic [14:0]               base;
        logic                      flip;
        logic                      sat_en;
        logic                      defined;
        logic                      mode;
        logic [12:0]               alpha;
        logic signed [PROD_W-1:0]  t3_hsl;
        logic signed [PROD_W-1:0]  s2_hwb;
        logic signed [PROD_W-1:0]  t3_hwb;
    } t_side;

    // round x / 2^f to nearest, halves away from zero
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] x, input int f);
        logic [PROD_W-1:0] a;
        a = x < 0 ? PROD_W'(-x) : PROD_W'(x);
        a = (a + (PROD_W'(1) << (f - 1))) >> f;
        return x < 0 ? -signed'(a) : signed'(a);
    endfunction

    function automatic logic signed [17:0] clamp_s18(input logic signed [PROD_W-1:0] x);
        if (x > PROD_W'(131071)) return 18'sd131071;
        if (x < -PROD_W'(131072)) return -18'sd131072;
        return x[17:0];
    endfunction

    function automatic logic signed [15:0] clamp_s16(input logic signed [PROD_W-1:0] x);
        if (x > PROD_W'(32767)) return 16'sd32767;
        if (x < -PROD_W'(32768)) return -16'sd32768;
        return x[15:0];
    endfunction
endpackage

@@ rtl/rhh_front.sv @@
`timescale 1ns / 1ps
// Front end: takes pixel words, finds max/min and the hue sextant, holds the mode register.
// Depends on rhh_pkg.
module rhh_front import rhh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    input  logic signed [13:0] i_red,
    input  logic signed [13:0] i_green,
    input  logic signed [13:0] i_blue,
    input  logic [12:0]        i_alpha_in,
    input  logic               i_q_full,
    output logic               o_push,
    output t_item              o_item
);
    logic  r_mode, n_mode;
    logic  r_valid, n_valid;
    t_item r_item, n_item;
    logic  w_take;
    logic signed [14:0] w_r, w_g, w_b;

    assign busy        = r_valid && i_q_full;
    assign w_take      = start && !busy;
    assign o_push      = r_valid && !i_q_full;
    assign o_item      = r_item;
    assign o_cfg_ready = 1'b1;
    assign w_r = 15'(i_red);
    assign w_g = 15'(i_green);
    assign w_b = 15'(i_blue);

    always_comb begin
        n_mode  = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_mode;
        n_valid = w_take ? 1'b1 : (o_push ? 1'b0 : r_valid);
        n_item  = r_item;
        if (w_take) begin
            n_item.mode  = r_mode;
            n_item.alpha = i_alpha_in;
            if (i_red >= i_green && i_red >= i_blue) begin
                n_item.mx   = i_red;
                n_item.diff = w_g - w_b;
                n_item.base = (i_green < i_blue) ? 15'(HUE_FULL) : '0;
            end else if (i_green >= i_blue) begin
                n_item.mx   = i_green;
                n_item.diff = w_b - w_r;
                n_item.base = 15'(HUE_GREEN);
            end else begin
                n_item.mx   = i_blue;
                n_item.diff = w_r - w_g;
                n_item.base = 15'(HUE_BLUE);
            end
            if (i_red <= i_green && i_red <= i_blue) begin
                n_item.mn = i_red;
            end else if (i_green <= i_blue) begin
                n_item.mn = i_green;
            end else begin
                n_item.mn = i_blue;
            end
            n_item.d       = 15'(15'(n_item.mx) - 15'(n_item.mn));
            n_item.sum     = 15'(n_item.mx) + 15'(n_item.mn);
            n_item.defined = n_item.mx != n_item.mn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end
endmodule

@@ rtl/rhh_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue between the front end and the back end.
// Depends on rhh_pkg.
module rhh_queue import rhh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);
    t_item      r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_wr, w_rd;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_wp  = w_wr ? !r_wp : r_wp;
        n_rp  = w_rd ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(w_wr) - 2'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

@@ rtl/rhh_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
// Depends on rhh_pkg.
module rhh_div import rhh_pkg::*; #(
    parameter int NW = HNUM_W,
    parameter int DW = HDEN_W,
    parameter int QW = QUO_W
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_big
);
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];
    logic          r_big [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [CW-1:0] w_rin, w_ds;
        logic [DW-1:0] w_din;
        logic [QW-1:0] w_qin;
        logic          w_bin;
        if (j == 0) begin : g_first
            assign w_rin = CW'(i_num);
            assign w_din = i_den;
            assign w_qin = '0;
            assign w_bin = CW'(i_num) >= (CW'(i_den) << QW);
        end else begin : g_next
            assign w_rin = r_rem[j-1];
            assign w_din = r_den[j-1];
            assign w_qin = r_quo[j-1];
            assign w_bin = r_big[j-1];
        end
        assign w_ds = CW'(w_din) << (QW - 1 - j);
        always_ff @(posedge i_clk) begin
            r_den[j] <= w_din;
            r_big[j] <= w_bin;
            if (w_rin >= w_ds) begin
                r_rem[j] <= w_rin - w_ds;
                r_quo[j] <= w_qin | (QW'(1) << (QW - 1 - j));
            end else begin
                r_rem[j] <= w_rin;
                r_quo[j] <= w_qin;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_big = r_big[QW-1];
endmodule

@@ rtl/rhh_back.sv @@
`timescale 1ns / 1ps
// Back end: numerators and denominators, hue and saturation dividers, final rounding.
// Depends on rhh_pkg, rhh_div and the assertion macro header.
`include "rgb_to_hsl_hwb_converter_macros.svh"
module rhh_back import rhh_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_result_valid,
    output logic [14:0]        o_hue,
    output logic               o_hue_defined,
    output logic signed [17:0] o_second_value,
    output logic signed [15:0] o_third_value,
    output logic [12:0]        o_alpha_out
);
    localparam int SW = ((FRACTION_BITS + 2 > 15) ? FRACTION_BITS + 2 : 15) + 2;

    t_side               r_side [QUO_W+1];
    t_side               n_side0;
    logic [QUO_W:0]      r_vld;
    logic [HNUM_W-1:0]   r_hn, n_hn;
    logic [HDEN_W-1:0]   r_hd, n_hd;
    logic [SNUM_W-1:0]   r_sn, n_sn;
    logic [SW-1:0]       r_sd, n_sd;
    logic [QUO_W-1:0]    w_hq, w_sq;
    logic                w_hbig, w_sbig;
    logic signed [SW-1:0] w_sum, w_two, w_alt, w_den;
    logic [SW-1:0]       w_aden;
    logic [14:0]         w_adiff;
    logic signed [17:0]  w_hue, w_hq_s;
    logic signed [17:0]  n_second;
    logic signed [15:0]  n_third;
    logic                r_out_valid;
    logic [14:0]         r_hue;
    logic                r_def;
    logic signed [17:0]  r_second;
    logic signed [15:0]  r_third;
    logic [12:0]         r_alpha;
    t_side               w_t;

    assign o_pop = i_valid;

    always_comb begin
        w_adiff = i_item.diff < 0 ? 15'(-i_item.diff) : 15'(i_item.diff);
        n_hn    = HNUM_W'(w_adiff) * HNUM_W'(HUE_NUM_SCALE) + HNUM_W'(i_item.d);
        n_hd    = {i_item.d[13:0], 1'b0};
        w_sum   = SW'(i_item.sum);
        w_two   = SW'(1) <<< (FRACTION_BITS + 1);
        w_alt   = w_two - w_sum;
        w_den   = (w_sum < w_alt) ? w_sum : w_alt;
        w_aden  = w_den < 0 ? SW'(-w_den) : SW'(w_den);
        n_sn    = SNUM_W'(i_item.d) * SNUM_W'(SAT_NUM_SCALE) + SNUM_W'(w_aden);
        n_sd    = SW'(w_aden << 1);
        n_side0.hue_neg = i_item.diff < 0;
        n_side0.base    = i_item.base;
        n_side0.sat_en  = !i_item.mode && i_item.defined && i_item.sum != 0 && w_sum != w_two;
        n_side0.flip    = n_side0.sat_en && w_den < 0;
        n_side0.defined = i_item.defined;
        n_side0.mode    = i_item.mode;
        n_side0.alpha   = i_item.alpha;
        n_side0.t3_hsl  = PROD_W'(i_item.sum) * PROD_W'(signed'(3200));
        n_side0.s2_hwb  = PROD_W'(i_item.mn) * PROD_W'(signed'(6400));
        n_side0.t3_hwb  = ((PROD_W'(signed'(1)) <<< FRACTION_BITS) - PROD_W'(i_item.mx))
                          * PROD_W'(signed'(6400));
    end

    always_ff @(posedge i_clk) begin
        r_hn      <= n_hn;
        r_hd      <= n_hd;
        r_sn      <= n_sn;
        r_sd      <= n_sd;
        r_side[0] <= n_side0;
        for (int k = 1; k <= QUO_W; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    rhh_div #(.NW(HNUM_W), .DW(HDEN_W), .QW(QUO_W)) u_hue_div (
        .i_clk (i_clk), .i_num (r_hn), .i_den (r_hd), .o_quo (w_hq), .o_big (w_hbig)
    );

    rhh_div #(.NW(SNUM_W), .DW(SW), .QW(QUO_W)) u_sat_div (
        .i_clk (i_clk), .i_num (r_sn), .i_den (r_sd), .o_quo (w_sq), .o_big (w_sbig)
    );

    always_comb begin
        w_t    = r_side[QUO_W];
        w_hq_s = signed'({1'b0, w_hq});
        w_hue  = signed'(18'(w_t.base)) + (w_t.hue_neg ? -w_hq_s : w_hq_s)
               + (w_t.flip ? 18'sd11520 : 18'sd0);
        if (w_hue >= 18'sd23040) begin
            w_hue = w_hue - 18'sd23040;
        end
        if (!w_t.defined) begin
            w_hue = '0;
        end
        if (w_t.mode) begin
            n_second = clamp_s18(rnd_shift(w_t.s2_hwb, FRACTION_BITS));
            n_third  = clamp_s16(rnd_shift(w_t.t3_hwb, FRACTION_BITS));
        end else begin
            n_second = !w_t.sat_en ? 18'sd0 :
                       (w_sbig ? signed'({1'b0, SAT_MAX}) : signed'({1'b0, w_sq}));
            n_third  = clamp_s16(rnd_shift(w_t.t3_hsl, FRACTION_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_vld       <= {r_vld[QUO_W-1:0], i_valid};
            r_out_valid <= r_vld[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue    <= w_hue[14:0];
        r_def    <= w_t.defined;
        r_second <= n_second;
        r_third  <= n_third;
        r_alpha  <= w_t.alpha;
    end

    assign o_result_valid = r_out_valid;
    assign o_hue          = r_hue;
    assign o_hue_defined  = r_def;
    assign o_second_value = r_second;
    assign o_third_value  = r_third;
    assign o_alpha_out    = r_alpha;

    `RHH_ASSERT_IMPLY(a_hue_no_ovf, i_clk, i_rst_n, r_vld[QUO_W] && w_t.defined, !w_hbig)
    `RHH_ASSERT_NEXT(a_hue_range, i_clk, i_rst_n, r_vld[QUO_W], r_hue < 15'd23040)
    `RHH_ASSERT_IMPLY(a_achrom_hue, i_clk, i_rst_n, o_result_valid && !o_hue_defined, o_hue == '0)
endmodule

@@ rtl/rgb_to_hsl_hwb_converter.sv @@
`timescale 1ns / 1ps
// RGB to HSL/HWB converter top level: front end, queue, back end.
// Depends on rhh_pkg, rhh_front, rhh_queue, rhh_back.
//
// Usage:
//   Pixel words enter on i_red/i_green/i_blue/i_alpha_in and are taken at a clock
//   edge where start is high and busy is low. One word can be taken every cycle.
//   Each word gives one result word on o_hue..o_alpha_out, shown for one cycle with
//   o_result_valid high; the receiver must take it then, it cannot hold off.
//   A word passes one front stage, one queue slot, one setup stage, 17 divider
//   stages (one quotient bit each for hue and saturation) and the output register.
//   Throughput is one word per cycle; busy only rises if the queue fills.
//   The mode register is written on the cfg channel (i_cfg_valid/o_cfg_ready,
//   i_cfg_data); 0 = HSL, 1 = HWB. The user must write it only while no word is in
//   flight; the block itself does not enforce this.
//   Synchronous active-low reset clears the mode to HSL and empties the pipeline.
module rgb_to_hsl_hwb_converter import rhh_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    input  logic signed [13:0] i_red,
    input  logic signed [13:0] i_green,
    input  logic signed [13:0] i_blue,
    input  logic [12:0]        i_alpha_in,
    output logic               o_result_valid,
    output logic [14:0]        o_hue,
    output logic               o_hue_defined,
    output logic signed [17:0] o_second_value,
    output logic signed [15:0] o_third_value,
    output logic [12:0]        o_alpha_out
);
    t_item w_f_item, w_q_item;
    logic  w_push, w_full, w_q_valid, w_pop;

    rhh_front u_front (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .start (start), .busy (busy),
        .i_cfg_valid (i_cfg_valid), .o_cfg_ready (o_cfg_ready), .i_cfg_data (i_cfg_data),
        .i_red (i_red), .i_green (i_green), .i_blue (i_blue), .i_alpha_in (i_alpha_in),
        .i_q_full (w_full), .o_push (w_push), .o_item (w_f_item)
    );

    rhh_queue u_queue (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_push (w_push), .i_item (w_f_item),
        .i_pop (w_pop), .o_full (w_full), .o_valid (w_q_valid), .o_item (w_q_item)
    );

    rhh_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (w_q_valid), .i_item (w_q_item),
        .o_pop (w_pop), .o_result_valid (o_result_valid), .o_hue (o_hue),
        .o_hue_defined (o_hue_defined), .o_second_value (o_second_value),
        .o_third_value (o_third_value), .o_alpha_out (o_alpha_out)
    );
endmodule

@@ bench/tb_rgb_to_hsl_hwb_converter.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rgb_to_hsl_hwb_converter: directed and random pixel words,
// HSL and HWB modes, predicted results compared in order. Depends on rhh_pkg and the RTL.
module tb_rgb_to_hsl_hwb_converter;
    import rhh_pkg::*;

    localparam int ONE   = 1 << FRACTION_BITS_DEF;
    localparam int SEXT  = 3840;
    localparam int PCT   = 6400;
    localparam int LAT   = 21;

    typedef struct packed {
        logic signed [13:0] r;
        logic signed [13:0] g;
        logic signed [13:0] b;
        logic [12:0]        a;
    } t_pixel;

    typedef struct packed {
        logic [14:0]        hue;
        logic               defined;
        logic signed [17:0] second;
        logic signed [15:0] third;
        logic [12:0]        alpha;
    } t_color;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_data = 1'b0;
    logic signed [13:0] i_red = '0;
    logic signed [13:0] i_green = '0;
    logic signed [13:0] i_blue = '0;
    logic [12:0]        i_alpha_in = '0;
    logic               o_result_valid;
    logic [14:0]        o_hue;
    logic               o_hue_defined;
    logic signed [17:0] o_second_value;
    logic signed [15:0] o_third_value;
    logic [12:0]        o_alpha_out;

    rgb_to_hsl_hwb_converter dut (.*);

    always #5 i_clk = ~i_clk;

    t_pixel pending_px[$];
    logic   pending_mode[$];
    t_color expected_colors[$];
    logic   mode_q = 1'b0;
    logic   cur_mode = 1'b0;
    int     errors = 0;
    int     checked = 0;
    int     gap_left = 0;
    bit     quiet = 1'b0;
    bit     hold = 1'b0;
    bit     word_out = 1'b0;
    bit     took = 1'b0;

    function automatic longint div_round(longint num, longint den);
        if (num >= 0) return (2 * num + den) / (2 * den);
        return -((-2 * num + den) / (2 * den));
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_color convert_pixel(t_pixel p, logic mode);
        t_color c;
        longint r, g, b, mx, mn, d, sum, hue, sec, thd, den;
        r = p.r; g = p.g; b = p.b;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sum = mx + mn;
        hue = 0;
        if (d != 0) begin
            if (mx == r) hue = div_round((g - b) * SEXT, d) + (g < b ? 6 * SEXT : 0);
            else if (mx == g) hue = div_round((b - r) * SEXT, d) + 2 * SEXT;
            else hue = div_round((r - g) * SEXT, d) + 4 * SEXT;
        end
        if (mode == 1'b0) begin
            sec = 0;
            if (d != 0 && sum != 0 && sum != 2 * ONE) begin
                den = sum < 2 * ONE - sum ? sum : 2 * ONE - sum;
                if (den < 0) begin
                    hue += HUE_HALF;
                    den = -den;
                end
                sec = div_round(d * PCT, den);
            end
            if (sec > 131071) sec = 131071;
            thd = div_round(sum * (PCT / 2), ONE);
        end else begin
            sec = div_round(mn * PCT, ONE);
            thd = div_round((ONE - mx) * PCT, ONE);
        end
        if (hue >= HUE_FULL) hue -= HUE_FULL;
        if (d == 0) hue = 0;
        c.hue = hue[14:0];
        c.defined = d != 0;
        c.second = 18'(clip(sec, -131072, 131071));
        c.third = 16'(clip(thd, -32768, 32767));
        c.alpha = p.a;
        return c;
    endfunction

    // accept seen at the rising edge
    always @(posedge i_clk) begin
        took <= i_rst_n && start && !busy;
    end

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (took) begin
                expected_colors.push_back(convert_pixel({i_red, i_green, i_blue, i_alpha_in},
                                                        cur_mode));
                word_out = 1'b0;
            end
            if (word_out) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (!hold && pending_px.size() > 0 && pending_mode[0] == mode_q) begin
                t_pixel p;
                p = pending_px.pop_front();
                void'(pending_mode.pop_front());
                cur_mode = mode_q;
                i_red <= p.r; i_green <= p.g; i_blue <= p.b; i_alpha_in <= p.a;
                start <= 1'b1;
                word_out = 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 11);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            t_color got, want;
            got = {o_hue, o_hue_defined, o_second_value, o_third_value, o_alpha_out};
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_colors.pop_front();
                checked++;
                if (got.hue != want.hue || got.defined != want.defined
                    || got.second != want.second || got.third != want.third
                    || got.alpha != want.alpha) begin
                    $display("%0t: mismatch exp hue %0d def %0b s %0d t %0d a %0d",
                             $time, want.hue, want.defined, want.second, want.third,
                             want.alpha);
                    $display("%0t:          got hue %0d def %0b s %0d t %0d a %0d",
                             $time, got.hue, got.defined, got.second, got.third, got.alpha);
                    errors++;
                end
            end
        end
    end

    task automatic add_pixel(int r, int g, int b, int a, logic mode);
        t_pixel p;
        p.r = 14'(r); p.g = 14'(g); p.b = 14'(b); p.a = 13'(a);
        pending_px.push_back(p);
        pending_mode.push_back(mode);
    endtask

    task automatic add_random(logic mode);
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            add_pixel($urandom_range(0, ONE), $urandom_range(0, ONE), $urandom_range(0, ONE),
                      $urandom_range(0, 4096), mode);
        else if (k < 7)
            add_pixel($urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192,
                      $urandom_range(0, 16383) - 8192, $urandom_range(0, 8191), mode);
        else if (k < 8) begin
            int v;
            v = $urandom_range(0, 16383) - 8192;
            add_pixel(v, v, $urandom_range(0, 1) ? v : v + 1, $urandom_range(0, 4096), mode);
        end else
            add_pixel($urandom_range(0, 2) * ONE, $urandom_range(0, 2) * ONE - ($urandom & 1),
                      ONE - $urandom_range(0, 2), $urandom_range(0, 4096), mode);
    endtask

    task automatic drain();
        while (pending_px.size() > 0 || word_out || start || expected_colors.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 5) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        @(negedge i_clk);
        i_cfg_data <= m;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        mode_q = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic modes[4];
        modes = '{1'b0, 1'b1, 1'b0, 1'b1};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) write_mode(modes[ph]);
            else mode_q = 1'b0;
            if (ph < 2) begin
                add_pixel(0, 0, 0, 0, modes[ph]);
                add_pixel(ONE, ONE, ONE, 4096, modes[ph]);
                add_pixel(8191, -8192, 0, 8191, modes[ph]);
                add_pixel(-8192, 8191, -8192, 1, modes[ph]);
                add_pixel(0, -8192, 8191, 4096, modes[ph]);
                add_pixel(ONE, 0, ONE, 100, modes[ph]);
                add_pixel(ONE, ONE, 0, 200, modes[ph]);
                add_pixel(0, ONE, ONE, 300, modes[ph]);
                add_pixel(ONE, 10, 0, 5, modes[ph]);
                add_pixel(ONE, 0, 10, 6, modes[ph]);
                add_pixel(1, 0, -1, 7, modes[ph]);
                add_pixel(8191, 8191, 0, 8, modes[ph]);
                add_pixel(-100, -200, -300, 9, modes[ph]);
                add_pixel(8000, 8191, 8100, 10, modes[ph]);
                add_pixel(-8192, -8192, -8192, 11, modes[ph]);
            end
            for (int i = 0; i < 110; i++) add_random(modes[ph]);
            if (ph == 1) begin
                hold = 1'b1;
                while (word_out || start || expected_colors.size() > 0) @(posedge i_clk);
                hold = 1'b0;
            end
            if (ph == 3) quiet = 1'b1;
            drain();
        end
        $display("Checked %0d result words over HSL and HWB modes, directed and random.",
                 checked);
        if (errors == 0 && expected_colors.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
